// ----- hdl/caf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_pkg
// Operation codes and flag types shared by the ALU (8-bit operations plus 16-bit adds) and its wrapper.
// ----------------------------------------------------------------------------
package caf_pkg;

   localparam int unsigned CmdWidth  = 5;
   localparam int unsigned DataWidth = 16;
   localparam int unsigned ByteWidth = 8;

   typedef enum logic [CmdWidth-1:0] {
      CMD_ADD   = 5'd0,
      CMD_ADC   = 5'd1,
      CMD_SUB   = 5'd2,
      CMD_SBC   = 5'd3,
      CMD_AND   = 5'd4,
      CMD_XOR   = 5'd5,
      CMD_OR    = 5'd6,
      CMD_CP    = 5'd7,
      CMD_INC   = 5'd8,
      CMD_DEC   = 5'd9,
      CMD_DAA   = 5'd10,
      CMD_CPL   = 5'd11,
      CMD_CCF   = 5'd12,
      CMD_SCF   = 5'd13,
      CMD_RLCA  = 5'd14,
      CMD_RLA   = 5'd15,
      CMD_RRCA  = 5'd16,
      CMD_RRA   = 5'd17,
      CMD_ADD16 = 5'd18,
      CMD_ADDSP = 5'd19
   } cmd_type;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   localparam logic [ByteWidth-1:0] DaaHiAdj   = 8'h60;
   localparam logic [ByteWidth-1:0] DaaLoAdj   = 8'h06;
   localparam logic [ByteWidth-1:0] DaaHiLimit = 8'h99;
   localparam logic [3:0]           DaaLoLimit = 4'h9;

endpackage

// ----- hdl/caf_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_alu
// Combinational datapath: one ALU operation with its flag update.
// ----------------------------------------------------------------------------
module caf_alu (
   input  logic [caf_pkg::CmdWidth-1:0]  cmd,
   input  logic [caf_pkg::DataWidth-1:0] x,
   input  logic [caf_pkg::DataWidth-1:0] y,
   input  caf_pkg::flags_type            flags_i,
   output logic [caf_pkg::DataWidth-1:0] result,
   output caf_pkg::flags_type            flags_o
);
   import caf_pkg::*;

   logic [ByteWidth-1:0] a;
   logic [ByteWidth-1:0] b;
   logic                 cin;
   logic [ByteWidth:0]   add9;
   logic [4:0]           add_nib;
   logic [ByteWidth:0]   sub9;
   logic [4:0]           sub_nib;
   logic [ByteWidth-1:0] inc8;
   logic [ByteWidth-1:0] dec8;
   logic                 daa_hi;
   logic                 daa_lo;
   logic [ByteWidth-1:0] daa8;
   logic [DataWidth:0]   add17;
   logic [12:0]          add13;
   logic [ByteWidth:0]   sp9;
   logic [4:0]           sp_nib;
   logic [DataWidth-1:0] sp16;
   logic [ByteWidth-1:0] r8;

   assign a   = x[ByteWidth-1:0];
   assign b   = y[ByteWidth-1:0];
   assign cin = (cmd == CMD_ADC || cmd == CMD_SBC) ? flags_i.c : 1'b0;

   assign add9    = {1'b0, a} + {1'b0, b} + {8'd0, cin};
   assign add_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
   assign sub9    = {1'b0, a} - {1'b0, b} - {8'd0, cin};
   assign sub_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
   assign inc8    = a + 8'd1;
   assign dec8    = a - 8'd1;

   // decimal adjust
   assign daa_hi = flags_i.c | (a > DaaHiLimit);
   assign daa_lo = flags_i.h | (a[3:0] > DaaLoLimit);
   always_comb begin
      if (!flags_i.n) begin
         daa8 = a + (daa_hi ? DaaHiAdj : 8'd0) + (daa_lo ? DaaLoAdj : 8'd0);
      end else begin
         daa8 = a - (flags_i.c ? DaaHiAdj : 8'd0) - (flags_i.h ? DaaLoAdj : 8'd0);
      end
   end

   assign add17  = {1'b0, x} + {1'b0, y};
   assign add13  = {1'b0, x[11:0]} + {1'b0, y[11:0]};
   assign sp9    = {1'b0, x[ByteWidth-1:0]} + {1'b0, b};
   assign sp_nib = {1'b0, x[3:0]} + {1'b0, b[3:0]};
   assign sp16   = x + {{ByteWidth{b[ByteWidth-1]}}, b};

   always_comb begin
      r8      = a;
      flags_o = flags_i;
      result  = x;
      case (cmd)
         CMD_ADD, CMD_ADC: begin
            r8      = add9[ByteWidth-1:0];
            flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: add_nib[4], c: add9[ByteWidth]};
         end
         CMD_SUB, CMD_SBC: begin
            r8      = sub9[ByteWidth-1:0];
            flags_o = '{z: (r8 == 8'd0), n: 1'b1, h: sub_nib[4], c: sub9[ByteWidth]};
         end
         CMD_CP: begin
            flags_o = '{z: (sub9[ByteWidth-1:0] == 8'd0), n: 1'b1, h: sub_nib[4],
                        c: sub9[ByteWidth]};
         end
         CMD_AND: begin
            r8      = a & b;
            flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         CMD_XOR: begin
            r8      = a ^ b;
            flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         CMD_OR: begin
            r8      = a | b;
            flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         CMD_INC: begin
            r8      = inc8;
            flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: (r8[3:0] == 4'h0), c: flags_i.c};
         end
         CMD_DEC: begin
            r8      = dec8;
            flags_o = '{z: (r8 == 8'd0), n: 1'b1, h: (r8[3:0] == 4'hF), c: flags_i.c};
         end
         CMD_DAA: begin
            r8      = daa8;
            flags_o = '{z: (r8 == 8'd0), n: flags_i.n, h: 1'b0,
                        c: flags_i.c | (!flags_i.n & daa_hi)};
         end
         CMD_CPL: begin
            r8      = ~a;
            flags_o = '{z: flags_i.z, n: 1'b1, h: 1'b1, c: flags_i.c};
         end
         CMD_CCF: begin
            flags_o = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: ~flags_i.c};
         end
         CMD_SCF: begin
            flags_o = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: 1'b1};
         end
         CMD_RLCA: begin
            r8      = {a[6:0], a[7]};
            flags_o = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
         end
         CMD_RLA: begin
            r8      = {a[6:0], flags_i.c};
            flags_o = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
         end
         CMD_RRCA: begin
            r8      = {a[0], a[7:1]};
            flags_o = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
         end
         CMD_RRA: begin
            r8      = {flags_i.c, a[7:1]};
            flags_o = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
         end
         default: begin
         end
      endcase

      case (cmd)
         CMD_ADD16: begin
            result  = add17[DataWidth-1:0];
            flags_o = '{z: flags_i.z, n: 1'b0, h: add13[12], c: add17[DataWidth]};
         end
         CMD_ADDSP: begin
            result  = sp16;
            flags_o = '{z: 1'b0, n: 1'b0, h: sp_nib[4], c: sp9[ByteWidth]};
         end
         default: begin
            if (cmd <= CMD_RRA) begin
               result = {8'd0, r8};
            end
         end
      endcase
   end

endmodule

// ----- hdl/cpu_alu_with_flags_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_unit
// 8-bit CPU ALU, plus 16-bit adds, with zero, subtract, half-carry and carry flags.
// ----------------------------------------------------------------------------
// A request is taken on every clock where start is high; busy never rises.
// Each request gives one response, marked by rsp_valid for one cycle: one
// register stage captures the request and one the result, with a single pass
// of ALU logic between them. The receiver cannot stall, so a response must be
// taken in the cycle it appears.
module cpu_alu_with_flags_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [4:0]  req_command,
   input  logic [15:0] req_first_operand,
   input  logic [15:0] req_second_operand,
   input  logic        req_zero_in,
   input  logic        req_subtract_in,
   input  logic        req_half_in,
   input  logic        req_carry_in,
   output logic        rsp_valid,
   output logic [15:0] rsp_result_value,
   output logic        rsp_zero_out,
   output logic        rsp_subtract_out,
   output logic        rsp_half_out,
   output logic        rsp_carry_out
);
   import caf_pkg::*;

   logic                 req_valid_ff;
   logic [CmdWidth-1:0]  cmd_ff;
   logic [DataWidth-1:0] x_ff;
   logic [DataWidth-1:0] y_ff;
   flags_type            flags_ff;
   logic                 rsp_valid_ff;
   logic [DataWidth-1:0] result_ff;
   flags_type            rsp_flags_ff;
   logic [DataWidth-1:0] result_in;
   flags_type            rsp_flags_in;
   logic                 req_take;

   assign busy     = 1'b0;
   assign req_take = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_take;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff   <= req_command;
         x_ff     <= req_first_operand;
         y_ff     <= req_second_operand;
         flags_ff <= '{z: req_zero_in, n: req_subtract_in, h: req_half_in,
                       c: req_carry_in};
      end
      if (req_valid_ff) begin
         result_ff    <= result_in;
         rsp_flags_ff <= rsp_flags_in;
      end
   end

   caf_alu u_alu (
      .cmd     (cmd_ff),
      .x       (x_ff),
      .y       (y_ff),
      .flags_i (flags_ff),
      .result  (result_in),
      .flags_o (rsp_flags_in)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = result_ff;
   assign rsp_zero_out     = rsp_flags_ff.z;
   assign rsp_subtract_out = rsp_flags_ff.n;
   assign rsp_half_out     = rsp_flags_ff.h;
   assign rsp_carry_out    = rsp_flags_ff.c;

   a_rsp_follows_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2))
      else $error("response without a request two cycles earlier");

   a_byte_op_upper_zero : assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && cmd_ff <= CMD_RRA) |=> (rsp_result_value[15:8] == 8'd0))
      else $error("byte operation returned nonzero upper byte");

   a_rotate_flags : assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && (cmd_ff == CMD_RLCA || cmd_ff == CMD_RLA ||
                        cmd_ff == CMD_RRCA || cmd_ff == CMD_RRA))
      |=> (!rsp_zero_out && !rsp_subtract_out && !rsp_half_out))
      else $error("rotate left zero, subtract or half-carry set");

endmodule
